/* rtl/sliding_window_base_composition_check_assert.svh */
// Assertion macros shared by the sliding window base composition check.
// Depends on nothing; included by the top level.
`ifndef SLIDING_WINDOW_BASE_COMPOSITION_CHECK_ASSERT_SVH
`define SLIDING_WINDOW_BASE_COMPOSITION_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SWBCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swbcc same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define SWBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swbcc next-cycle check failed");

`endif

/* rtl/swbcc_pkg.sv */
// Package for the sliding window base composition check.
// Holds symbol codes, register indexes and the stage control struct; no dependencies.
package swbcc_pkg;

    // Stored per-symbol code.
    typedef logic [2:0] code_t;
    localparam code_t CODE_OTHER = 3'd0;
    localparam code_t CODE_A     = 3'd1;
    localparam code_t CODE_C     = 3'd2;
    localparam code_t CODE_G     = 3'd3;
    localparam code_t CODE_T     = 3'd4;

    localparam int NUM_BASES = 4;

    // Character bytes that are counted.
    localparam logic [7:0] SYM_A = 8'h41;
    localparam logic [7:0] SYM_C = 8'h43;
    localparam logic [7:0] SYM_G = 8'h47;
    localparam logic [7:0] SYM_T = 8'h54;

    // Configuration register indexes and data width.
    localparam int CFG_W = 11;
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_WINDOW_LEN = 3'd0;
    localparam cfg_index_t CFG_MIN_A      = 3'd1;
    localparam cfg_index_t CFG_MIN_C      = 3'd2;
    localparam cfg_index_t CFG_MIN_G      = 3'd3;
    localparam cfg_index_t CFG_MIN_T      = 3'd4;

    // Control carried from the memory read stage into the count stage.
    typedef struct packed {
        logic evict;
        logic restart;
        logic full;
    } s1_ctrl_t;

    // Map a raw byte to its stored code.
    function automatic code_t classify(input logic [7:0] sym);
        code_t code;
        unique case (sym)
            SYM_A:   code = CODE_A;
            SYM_C:   code = CODE_C;
            SYM_G:   code = CODE_G;
            SYM_T:   code = CODE_T;
            default: code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

/* rtl/swbcc_counts.sv */
// Running base counts, threshold compare and saturating qualifying total.
// Depends on swbcc_pkg.
module swbcc_counts
    import swbcc_pkg::*;
#(
    parameter int CNT_W = 11
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             clear,
    input  s1_ctrl_t                         ctrl,
    input  code_t                            new_code,
    input  code_t                            old_code,
    input  logic [NUM_BASES-1:0][CFG_W-1:0]  min_cnt,
    output logic                             ok,
    output logic [31:0]                      total
);

    localparam int MW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0]     count_reg  [NUM_BASES];
    logic [CNT_W-1:0]     count_next [NUM_BASES];
    logic [CNT_W-1:0]     count_base [NUM_BASES];
    logic [NUM_BASES-1:0] dec;
    logic [NUM_BASES-1:0] inc;
    logic [NUM_BASES-1:0] met;
    logic [31:0]          total_reg;
    logic [31:0]          total_base;
    logic [31:0]          total_next;

    // Remove the leaving symbol, add the entering one, compare to the minimums.
    always_comb
    begin
        for (int i = 0; i < NUM_BASES; i++)
        begin
            count_base[i] = ctrl.restart ? '0 : count_reg[i];
            dec[i] = ctrl.evict && (old_code == code_t'(i + 1)) && (count_base[i] != '0);
            inc[i] = (new_code == code_t'(i + 1));
            count_next[i] = count_base[i] - CNT_W'(dec[i]) + CNT_W'(inc[i]);
            met[i] = (MW'(count_next[i]) >= MW'(min_cnt[i]));
        end
        ok = ctrl.full && (&met);
        total_base = ctrl.restart ? '0 : total_reg;
        total_next = (ok && (total_base != '1)) ? total_base + 32'd1 : total_base;
        total = total_next;
    end

    // Counts and total advance once per transaction leaving the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BASES; i++)
            begin
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (clear)
        begin
            for (int i = 0; i < NUM_BASES; i++)
            begin
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_BASES; i++)
            begin
                count_reg[i] <= count_next[i];
            end
            total_reg <= total_next;
        end
    end

endmodule

/* rtl/sliding_window_base_composition_check.sv */
// Top level of the sliding window base composition check.
// Depends on swbcc_pkg, swbcc_counts and the assertion macro header.
//
// Accepts one symbol transaction per clock while out_ready stays high and returns one
// result transaction per symbol through the read stage and the output register. The
// window lives in a WINDOW_MAX x 3 bit memory that takes one write (the entering symbol)
// and one read (the symbol leaving the window) per cycle; that single port pair sets the
// rate at one symbol per cycle. The running counts are updated in the stage after the
// read. Writing window_len clears the window, counts and total; cfg_ready is always high.
// Users must write configuration only while no transaction is in flight (not enforced).
`include "sliding_window_base_composition_check_assert.svh"

module sliding_window_base_composition_check
    import swbcc_pkg::*;
#(
    parameter int WINDOW_MAX = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       symbol,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             window_full,
    output logic             window_ok,
    output logic [31:0]      match_total,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int PW = LW + 1;
    localparam int LEN_RESET = (WINDOW_MAX < 4) ? WINDOW_MAX : 4;

    // Configuration registers.
    logic [LW-1:0]                    len_reg;
    logic [NUM_BASES-1:0][CFG_W-1:0]  min_reg;
    logic                             cfg_accept;
    logic                             clear_window;

    // Front state and window memory.
    logic [AW-1:0] wp_reg;
    logic [LW-1:0] fill_reg;
    code_t         mem [WINDOW_MAX];
    code_t         rd_code_reg;

    // Read stage and output register.
    logic          s1_valid_reg;
    s1_ctrl_t      s1_ctrl_reg;
    code_t         s1_code_reg;
    logic          out_valid_reg;
    logic          full_reg;
    logic          ok_reg;
    logic [31:0]   total_reg;

    logic          accept;
    logic          s1_adv;
    logic [AW-1:0] wp_cur;
    logic [AW-1:0] wp_next;
    logic [LW-1:0] fill_cur;
    logic [LW-1:0] fill_next;
    logic [AW-1:0] raddr;
    logic [PW-1:0] wp_ext;
    logic [PW-1:0] len_ext;
    code_t         in_code;
    s1_ctrl_t      s1_ctrl_next;
    logic          cnt_ok;
    logic [31:0]   cnt_total;

    // Handshakes.
    assign cfg_ready    = 1'b1;
    assign cfg_accept   = cfg_valid && cfg_ready;
    assign clear_window = cfg_accept && (cfg_index == CFG_WINDOW_LEN);
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !s1_valid_reg || s1_adv;
    assign accept       = in_valid && in_ready;

    // Configuration writes; window length is stored already limited to 1..WINDOW_MAX.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LW'(LEN_RESET);
            min_reg <= '0;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEN:
                begin
                    if (cfg_data == '0)
                        len_reg <= LW'(1);
                    else if (32'(cfg_data) > 32'(WINDOW_MAX))
                        len_reg <= LW'(WINDOW_MAX);
                    else
                        len_reg <= LW'(cfg_data);
                end
                CFG_MIN_A: min_reg[0] <= cfg_data;
                CFG_MIN_C: min_reg[1] <= cfg_data;
                CFG_MIN_G: min_reg[2] <= cfg_data;
                CFG_MIN_T: min_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Entry stage: pointer, fill level and address of the leaving symbol.
    always_comb
    begin
        in_code  = classify(symbol);
        wp_cur   = restart ? '0 : wp_reg;
        fill_cur = restart ? '0 : fill_reg;
        wp_ext   = PW'(wp_cur);
        len_ext  = PW'(len_reg);
        if (wp_ext >= len_ext)
            raddr = AW'(wp_ext - len_ext);
        else
            raddr = AW'(wp_ext + PW'(WINDOW_MAX) - len_ext);
        wp_next = (wp_cur == AW'(WINDOW_MAX - 1)) ? '0 : wp_cur + AW'(1);
        s1_ctrl_next.evict   = (fill_cur >= len_reg);
        s1_ctrl_next.restart = restart;
        s1_ctrl_next.full    = s1_ctrl_next.evict || ((fill_cur + LW'(1)) == len_reg);
        fill_next = s1_ctrl_next.evict ? fill_cur : fill_cur + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (clear_window)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // Window memory: read-before-write, so a full-depth window reads the evicted entry.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_code_reg <= mem[raddr];
            mem[wp_cur] <= in_code;
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_code_reg <= in_code;
        end
    end

    // Count update and threshold compare.
    swbcc_counts #(
        .CNT_W (LW)
    ) u_counts (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (s1_adv),
        .clear    (clear_window),
        .ctrl     (s1_ctrl_reg),
        .new_code (s1_code_reg),
        .old_code (rd_code_reg),
        .min_cnt  (min_reg),
        .ok       (cnt_ok),
        .total    (cnt_total)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            full_reg  <= s1_ctrl_reg.full;
            ok_reg    <= cnt_ok;
            total_reg <= cnt_total;
        end
    end

    assign out_valid   = out_valid_reg;
    assign window_full = full_reg;
    assign window_ok   = ok_reg;
    assign match_total = total_reg;

    // Checks on the pipeline and window bookkeeping.
    `SWBCC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)
    `SWBCC_ASSERT_NEXT(a_read_data_held, clk, rst_n, s1_valid_reg && !s1_adv, $stable(rd_code_reg))
    `SWBCC_ASSERT_NOW(a_fill_within_len, clk, rst_n, 1'b1, fill_reg <= len_reg)
    `SWBCC_ASSERT_NOW(a_ok_needs_full, clk, rst_n, out_valid_reg, !ok_reg || full_reg)

endmodule

/* verif/composition_checker.sv */
// Checker for the sliding window base composition check: watches the three channels,
// predicts every result transaction and compares it field by field.
// Depends on swbcc_pkg for the symbol bytes, stored codes and register indexes.
`timescale 1ns / 100ps

module composition_checker
    import swbcc_pkg::*;
#(
    parameter int WINDOW_MAX = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       symbol,
    input  logic             restart,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             window_full,
    input  logic             window_ok,
    input  logic [31:0]      match_total,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               reports_due
);

    // One predicted result transaction.
    typedef struct packed {
        logic        full;
        logic        ok;
        logic [31:0] total;
    } window_report_t;

    // Predicted window contents and running counts.
    code_t            ring [WINDOW_MAX];
    int unsigned      head;
    int unsigned      fill;
    logic [10:0]      base_cnt [CODE_A:CODE_T];
    logic [31:0]      total;

    // Copy of the configuration registers.
    logic [CFG_W-1:0] len_reg;
    logic [CFG_W-1:0] min_reg [CODE_A:CODE_T];

    window_report_t   pending_reports [$];
    window_report_t   want;

    function automatic code_t base_code(input logic [7:0] sym);
        case (sym)
            SYM_A:   return CODE_A;
            SYM_C:   return CODE_C;
            SYM_G:   return CODE_G;
            SYM_T:   return CODE_T;
            default: return CODE_OTHER;
        endcase
    endfunction

    function automatic void clear_window();
        head  = 0;
        fill  = 0;
        total = '0;
        for (int b = CODE_A; b <= CODE_T; b++)
        begin
            base_cnt[b] = '0;
        end
    endfunction

    // A window length write also starts a new string.
    function automatic void apply_config(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_WINDOW_LEN:
            begin
                len_reg = data;
                clear_window();
            end
            CFG_MIN_A: min_reg[CODE_A] = data;
            CFG_MIN_C: min_reg[CODE_C] = data;
            CFG_MIN_G: min_reg[CODE_G] = data;
            CFG_MIN_T: min_reg[CODE_T] = data;
            default:   ;
        endcase
    endfunction

    // Advance the window by one symbol and return the report it produces.
    function automatic window_report_t step_window(input logic [7:0] sym, input logic rs);
        int unsigned    span;
        int unsigned    oldest;
        code_t          code;
        code_t          leaving;
        window_report_t rep;
        if (len_reg == 0)
            span = 1;
        else if (len_reg > WINDOW_MAX)
            span = WINDOW_MAX;
        else
            span = 32'(len_reg);
        code = base_code(sym);
        if (rs)
            clear_window();

        // A full window drops its oldest symbol before the new one enters.
        if (fill >= span)
        begin
            oldest  = (head + WINDOW_MAX - span) % WINDOW_MAX;
            leaving = ring[oldest];
            if (leaving != CODE_OTHER && base_cnt[leaving] != 0)
                base_cnt[leaving] = base_cnt[leaving] - 11'd1;
        end
        else
        begin
            fill = fill + 1;
        end
        ring[head] = code;
        head = (head + 1) % WINDOW_MAX;
        if (code != CODE_OTHER)
            base_cnt[code] = base_cnt[code] + 11'd1;

        rep.full = (fill >= span);
        rep.ok   = rep.full;
        for (int b = CODE_A; b <= CODE_T; b++)
        begin
            if (base_cnt[b] < min_reg[b])
                rep.ok = 1'b0;
        end
        // The total saturates rather than wrapping.
        if (rep.ok && total != 32'hFFFF_FFFF)
            total = total + 32'd1;
        rep.total = total;
        return rep;
    endfunction

    // Sample all channels at the rising edge; configuration and symbols never overlap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            len_reg = 11'd4;
            for (int b = CODE_A; b <= CODE_T; b++)
            begin
                min_reg[b] = '0;
            end
            pending_reports.delete();
            fail_count  = 0;
            reports_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                pending_reports.push_back(step_window(symbol, restart));
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (window_full !== want.full)
                    begin
                        fail_count++;
                        $display("%0t: window_full expected %0d, actual %0d",
                                 $time, want.full, window_full);
                    end
                    if (window_ok !== want.ok)
                    begin
                        fail_count++;
                        $display("%0t: window_ok expected %0d, actual %0d",
                                 $time, want.ok, window_ok);
                    end
                    if (match_total !== want.total)
                    begin
                        fail_count++;
                        $display("%0t: match_total expected %0d, actual %0d",
                                 $time, want.total, match_total);
                    end
                end
            end
            reports_due = pending_reports.size();
        end
    end

endmodule

/* verif/tb.sv */
// Top of the testbench for the sliding window base composition check: drives symbol
// and configuration transactions with random idling and gives the verdict.
// Depends on swbcc_pkg, the block itself and composition_checker.
`timescale 1ns / 100ps

module tb;
    import swbcc_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       symbol;
    logic             restart;
    logic             out_valid;
    logic             out_ready;
    logic             window_full;
    logic             window_ok;
    logic [31:0]      match_total;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               fail_count;
    int               reports_due;
    bit               idle_on;
    int               stall_left;

    sliding_window_base_composition_check u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .symbol      (symbol),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_full (window_full),
        .window_ok   (window_ok),
        .match_total (match_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    composition_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .symbol      (symbol),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_full (window_full),
        .window_ok   (window_ok),
        .match_total (match_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls in random bursts while idling is on.
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Present one symbol transaction and hold it until accepted; valid stays high after.
    task automatic send_symbol(input logic [7:0] sym, input logic rs);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed bases, some arbitrary bytes, an occasional new string.
    task automatic send_random(input int restart_odds);
        logic [7:0] sym;
        logic       rs;
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 3))
                0:       sym = SYM_A;
                1:       sym = SYM_C;
                2:       sym = SYM_G;
                default: sym = SYM_T;
            endcase
        end
        else
        begin
            sym = 8'($urandom_range(0, 255));
        end
        rs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
        send_symbol(sym, rs);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Wait for idle, then write the registers (length only if asked) and one unused index.
    task automatic set_config(input bit with_len, input logic [CFG_W-1:0] len,
                              input logic [CFG_W-1:0] ma, input logic [CFG_W-1:0] mc,
                              input logic [CFG_W-1:0] mg, input logic [CFG_W-1:0] mt);
        cfg_index_t spare;
        in_valid <= 1'b0;
        while (reports_due != 0) @(negedge clk);
        if (with_len)
            write_reg(CFG_WINDOW_LEN, len);
        write_reg(CFG_MIN_A, ma);
        write_reg(CFG_MIN_C, mc);
        write_reg(CFG_MIN_G, mg);
        write_reg(CFG_MIN_T, mt);
        spare = cfg_index_t'($urandom_range(5, 7));
        write_reg(spare, CFG_W'($urandom_range(0, 2047)));
        cfg_valid <= 1'b0;
    endtask

    // Minimum for a small window; now and then one that cannot be met.
    function automatic logic [CFG_W-1:0] pick_min(input int span);
        if ($urandom_range(0, 7) == 0)
            return CFG_W'(span + 1);
        return CFG_W'($urandom_range(0, span / 5));
    endfunction

    // Stimulus.
    initial
    begin
        int span;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        symbol    = 8'h00;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_LEN;
        cfg_data  = '0;
        out_ready = 1'b0;
        idle_on   = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: window of four, no minimums.
        send_symbol(SYM_A, 1'b1);
        send_symbol(SYM_C, 1'b0);
        send_symbol(SYM_G, 1'b0);
        send_symbol(SYM_T, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h61, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_T, 1'b1);

        // Zero length acts as a window of one.
        set_config(1'b1, 11'd0, 11'd1, 11'd0, 11'd0, 11'd0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_C, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_A, 1'b1);

        // Minimums above the window length can never be met.
        set_config(1'b1, 11'd3, 11'd4, 11'd0, 11'd0, 11'h7FF);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_T, 1'b0);

        // Pair window needing an A and a T.
        set_config(1'b1, 11'd2, 11'd1, 11'd0, 11'd0, 11'd1);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_T, 1'b0);
        send_symbol(SYM_T, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_C, 1'b0);

        // Small windows; some phases change only the minimums and keep the string.
        for (int ph = 0; ph < 8; ph++)
        begin
            span = $urandom_range(1, 16);
            set_config(ph % 3 != 1, CFG_W'(span), pick_min(span), pick_min(span),
                       pick_min(span), pick_min(span));
            for (int i = 0; i < 100; i++)
            begin
                send_random(40);
                // The sender holds off once until every result is back.
                if (ph == 2 && i == 50)
                begin
                    in_valid <= 1'b0;
                    while (reports_due != 0) @(negedge clk);
                end
            end
        end

        // Length above the store depth saturates to the full 1024 entries.
        set_config(1'b1, 11'h7FF, CFG_W'($urandom_range(195, 215)),
                   CFG_W'($urandom_range(195, 215)), CFG_W'($urandom_range(195, 215)),
                   CFG_W'($urandom_range(195, 215)));
        for (int i = 0; i < 1060; i++)
        begin
            if (i == 900)
                idle_on = 1'b0;
            send_random(0);
        end
        in_valid <= 1'b0;

        while (reports_due != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && reports_due == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Hang guard.
    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule
